// ===== hdl/tcphs_pkg.sv =====
`timescale 1ns / 1ps

package tcphs_pkg;

   localparam int WORDS_PER_PKT = 20;
   localparam int WORD_CNT_W    = 5;
   localparam logic [WORD_CNT_W-1:0] WORD_LAST = WORD_CNT_W'(WORDS_PER_PKT - 1);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_SOURCE_ADDRESS = 3'd0,
      REG_DEST_ADDRESS   = 3'd1,
      REG_LOCAL_PORT     = 3'd2,
      REG_REMOTE_PORT    = 3'd3,
      REG_SYN_SEQUENCE   = 3'd4,
      REG_ACK_SEQUENCE   = 3'd5,
      REG_WINDOW_SIZE    = 3'd6,
      REG_IP_IDENT       = 3'd7
   } reg_index_type;

   localparam logic [31:0] RST_SOURCE_ADDRESS = 32'h7f00_0001;
   localparam logic [31:0] RST_DEST_ADDRESS   = 32'h7f00_0001;
   localparam logic [15:0] RST_LOCAL_PORT     = 16'd34463;
   localparam logic [15:0] RST_REMOTE_PORT    = 16'd12345;
   localparam logic [31:0] RST_SYN_SEQUENCE   = 32'd200;
   localparam logic [31:0] RST_ACK_SEQUENCE   = 32'd600;
   localparam logic [15:0] RST_WINDOW_SIZE    = 16'd8192;
   localparam logic [15:0] RST_IP_IDENT       = 16'd34463;

   localparam logic [15:0] IP_VER_TOS   = 16'h4500;
   localparam logic [15:0] IP_LENGTH    = 16'd40;
   localparam logic [15:0] IP_FRAG      = 16'h0000;
   localparam logic [15:0] IP_TTL_PROTO = 16'h4006;
   localparam logic [15:0] PSEUDO_CONST = 16'd26;   // protocol 6 + TCP length 20
   localparam logic [15:0] TCP_OFFSET   = 16'h5000;
   localparam logic [15:0] FLAG_SYN     = 16'h0002;
   localparam logic [15:0] FLAG_ACK     = 16'h0010;
   localparam logic [15:0] ZERO_WORD    = 16'h0000;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_SEGMENT = 1'b1;

   localparam logic KIND_SYN = 1'b0;
   localparam logic KIND_ACK = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_WAITING = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [31:0] syn_sequence;
      logic [31:0] ack_sequence;
      logic [15:0] window_size;
      logic [15:0] ip_ident;
   } cfg_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] ackno;
      logic        kind;
      logic [15:0] ip_csum;
      logic [15:0] tcp_csum;
   } entry_type;

endpackage

// ===== hdl/tcphs_ifs.sv =====
`timescale 1ns / 1ps

interface tcphs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] rx_source_port;
   logic [15:0] rx_dest_port;
   logic        rx_syn;
   logic        rx_ack;
   logic [31:0] rx_sequence;

   modport source (output valid, command, rx_source_port, rx_dest_port, rx_syn, rx_ack,
                   rx_sequence, input ready);
   modport sink   (input valid, command, rx_source_port, rx_dest_port, rx_syn, rx_ack,
                   rx_sequence, output ready);
endinterface

interface tcphs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] packet_word;
   logic        last_word;
   logic        packet_kind;

   modport source (output valid, packet_word, last_word, packet_kind, input ready);
   modport sink   (input valid, packet_word, last_word, packet_kind, output ready);
endinterface

// ===== hdl/tcphs_csr.sv =====
`timescale 1ns / 1ps

module tcphs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tcphs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output tcphs_pkg::cfg_type             cfg
);
   import tcphs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SOURCE_ADDRESS: cfg_in.source_address = csr_pwdata;
            REG_DEST_ADDRESS:   cfg_in.dest_address   = csr_pwdata;
            REG_LOCAL_PORT:     cfg_in.local_port     = csr_pwdata[15:0];
            REG_REMOTE_PORT:    cfg_in.remote_port    = csr_pwdata[15:0];
            REG_SYN_SEQUENCE:   cfg_in.syn_sequence   = csr_pwdata;
            REG_ACK_SEQUENCE:   cfg_in.ack_sequence   = csr_pwdata;
            REG_WINDOW_SIZE:    cfg_in.window_size    = csr_pwdata[15:0];
            REG_IP_IDENT:       cfg_in.ip_ident       = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SOURCE_ADDRESS: csr_prdata = cfg_ff.source_address;
         REG_DEST_ADDRESS:   csr_prdata = cfg_ff.dest_address;
         REG_LOCAL_PORT:     csr_prdata = {16'h0000, cfg_ff.local_port};
         REG_REMOTE_PORT:    csr_prdata = {16'h0000, cfg_ff.remote_port};
         REG_SYN_SEQUENCE:   csr_prdata = cfg_ff.syn_sequence;
         REG_ACK_SEQUENCE:   csr_prdata = cfg_ff.ack_sequence;
         REG_WINDOW_SIZE:    csr_prdata = {16'h0000, cfg_ff.window_size};
         REG_IP_IDENT:       csr_prdata = {16'h0000, cfg_ff.ip_ident};
         default:            csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address <= RST_SOURCE_ADDRESS;
         cfg_ff.dest_address   <= RST_DEST_ADDRESS;
         cfg_ff.local_port     <= RST_LOCAL_PORT;
         cfg_ff.remote_port    <= RST_REMOTE_PORT;
         cfg_ff.syn_sequence   <= RST_SYN_SEQUENCE;
         cfg_ff.ack_sequence   <= RST_ACK_SEQUENCE;
         cfg_ff.window_size    <= RST_WINDOW_SIZE;
         cfg_ff.ip_ident       <= RST_IP_IDENT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/tcphs_front.sv =====
`timescale 1ns / 1ps

module tcphs_front (
   input  logic                         clock,
   input  logic                         reset,
   tcphs_req_if.sink                    req_chan,
   input  tcphs_pkg::cfg_type           cfg,
   input  logic [tcphs_pkg::QCNT_W-1:0] q_count,
   output logic                         push,
   output tcphs_pkg::entry_type         push_data
);
   import tcphs_pkg::*;

   function automatic logic [15:0] csum_fold(input logic [19:0] s);
      logic [16:0] f;
      logic [15:0] g;
      f = {1'b0, s[15:0]} + {13'b0, s[19:16]};
      g = f[15:0] + {15'b0, f[16]};
      return ~g;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [31:0] peer_seq_ff, peer_seq_in;
   logic        hit, is_start, is_match, emit;
   logic [QCNT_W:0] in_flight;

   // stage 1
   logic        v1_ff;
   logic        kind1_ff;
   logic [31:0] seq1_ff;
   // stage 2
   logic        v2_ff;
   logic        kind2_ff;
   logic [31:0] seq2_ff, ack2_ff;
   logic [17:0] ip_a2_ff, ip_b2_ff, tcp_c2_ff;
   logic [18:0] tcp_b2_ff;
   // stage 3
   logic        v3_ff;
   logic        kind3_ff;
   logic [31:0] seq3_ff, ack3_ff;
   logic [18:0] ip_sum3_ff;
   logic [19:0] tcp_sum3_ff;

   logic [31:0] ackno1;
   logic [15:0] flags1;
   logic [17:0] ip_a1, ip_b1, tcp_c1;
   logic [18:0] tcp_b1;

   assign in_flight = {{(QCNT_W){1'b0}}, v1_ff} + {{(QCNT_W){1'b0}}, v2_ff}
                    + {{(QCNT_W){1'b0}}, v3_ff} + {1'b0, q_count};
   assign req_chan.ready = (in_flight < (QCNT_W+1)'(QDEPTH));
   assign hit      = req_chan.valid && req_chan.ready;
   assign is_start = (req_chan.command == CMD_START);

   // phase: next state
   always_comb begin
      phase_in = phase_ff;
      if (hit) begin
         if (is_start) begin
            phase_in = PH_WAITING;
         end else if (is_match) begin
            phase_in = PH_DONE;
         end
      end
   end

   // phase: outputs
   always_comb begin
      is_match = 1'b0;
      unique case (phase_ff)
         PH_WAITING: is_match = (req_chan.rx_source_port == cfg.remote_port)
                              && (req_chan.rx_dest_port == cfg.local_port)
                              && req_chan.rx_syn && req_chan.rx_ack;
         default:    is_match = 1'b0;
      endcase
   end

   assign emit        = hit && (is_start || is_match);
   assign peer_seq_in = (hit && !is_start && is_match) ? req_chan.rx_sequence : peer_seq_ff;

   always_comb begin
      ackno1 = (kind1_ff == KIND_ACK) ? peer_seq_ff + 32'd1 : 32'd0;
      flags1 = (kind1_ff == KIND_ACK) ? FLAG_ACK : FLAG_SYN;
      ip_a1  = {2'b0, IP_VER_TOS} + {2'b0, IP_LENGTH} + {2'b0, cfg.ip_ident}
             + {2'b0, IP_TTL_PROTO};
      ip_b1  = {2'b0, cfg.source_address[31:16]} + {2'b0, cfg.source_address[15:0]}
             + {2'b0, cfg.dest_address[31:16]} + {2'b0, cfg.dest_address[15:0]};
      tcp_b1 = {3'b0, cfg.local_port} + {3'b0, cfg.remote_port} + {3'b0, PSEUDO_CONST}
             + {3'b0, cfg.window_size} + {3'b0, TCP_OFFSET | flags1};
      tcp_c1 = {2'b0, seq1_ff[31:16]} + {2'b0, seq1_ff[15:0]}
             + {2'b0, ackno1[31:16]} + {2'b0, ackno1[15:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         peer_seq_ff <= 32'd0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         peer_seq_ff <= peer_seq_in;
         v1_ff       <= emit;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind1_ff    <= is_start ? KIND_SYN : KIND_ACK;
      seq1_ff     <= is_start ? cfg.syn_sequence : cfg.ack_sequence;

      kind2_ff    <= kind1_ff;
      seq2_ff     <= seq1_ff;
      ack2_ff     <= ackno1;
      ip_a2_ff    <= ip_a1;
      ip_b2_ff    <= ip_b1;
      tcp_b2_ff   <= tcp_b1;
      tcp_c2_ff   <= tcp_c1;

      kind3_ff    <= kind2_ff;
      seq3_ff     <= seq2_ff;
      ack3_ff     <= ack2_ff;
      ip_sum3_ff  <= {1'b0, ip_a2_ff} + {1'b0, ip_b2_ff};
      tcp_sum3_ff <= {2'b0, ip_b2_ff} + {1'b0, tcp_b2_ff} + {2'b0, tcp_c2_ff};
   end

   assign push               = v3_ff;
   assign push_data.seq      = seq3_ff;
   assign push_data.ackno    = ack3_ff;
   assign push_data.kind     = kind3_ff;
   assign push_data.ip_csum  = csum_fold({1'b0, ip_sum3_ff});
   assign push_data.tcp_csum = csum_fold(tcp_sum3_ff);

endmodule

// ===== hdl/tcphs_fifo.sv =====
`timescale 1ns / 1ps

module tcphs_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tcphs_pkg::entry_type         push_data,
   input  logic                         pop,
   output tcphs_pkg::entry_type         head,
   output logic [tcphs_pkg::QCNT_W-1:0] count
);
   import tcphs_pkg::*;

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tcphs_back.sv =====
`timescale 1ns / 1ps

module tcphs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tcphs_pkg::cfg_type           cfg,
   input  tcphs_pkg::entry_type         head,
   input  logic [tcphs_pkg::QCNT_W-1:0] q_count,
   output logic                         pop,
   tcphs_rsp_if.source                  rsp_chan
);
   import tcphs_pkg::*;

   logic [WORD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           word_ff, word_in;
   logic                  last_ff, kind_ff;
   logic                  advance, have;
   logic [15:0]           flags;

   assign have    = (q_count != '0);
   assign advance = have && (!out_valid_ff || rsp_chan.ready);
   assign pop     = advance && (cnt_ff == WORD_LAST);
   assign flags   = (head.kind == KIND_ACK) ? FLAG_ACK : FLAG_SYN;

   always_comb begin
      case (cnt_ff)
         5'd0:    word_in = IP_VER_TOS;
         5'd1:    word_in = IP_LENGTH;
         5'd2:    word_in = cfg.ip_ident;
         5'd3:    word_in = IP_FRAG;
         5'd4:    word_in = IP_TTL_PROTO;
         5'd5:    word_in = head.ip_csum;
         5'd6:    word_in = cfg.source_address[31:16];
         5'd7:    word_in = cfg.source_address[15:0];
         5'd8:    word_in = cfg.dest_address[31:16];
         5'd9:    word_in = cfg.dest_address[15:0];
         5'd10:   word_in = cfg.local_port;
         5'd11:   word_in = cfg.remote_port;
         5'd12:   word_in = head.seq[31:16];
         5'd13:   word_in = head.seq[15:0];
         5'd14:   word_in = head.ackno[31:16];
         5'd15:   word_in = head.ackno[15:0];
         5'd16:   word_in = TCP_OFFSET | flags;
         5'd17:   word_in = cfg.window_size;
         5'd18:   word_in = head.tcp_csum;
         default: word_in = ZERO_WORD;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (advance) begin
         out_valid_in = 1'b1;
         cnt_in       = (cnt_ff == WORD_LAST) ? '0 : cnt_ff + WORD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
         last_ff <= (cnt_ff == WORD_LAST);
         kind_ff <= head.kind;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.packet_word = word_ff;
   assign rsp_chan.last_word   = last_ff;
   assign rsp_chan.packet_kind = kind_ff;

endmodule

// ===== hdl/tcp_handshake_client_framer_top.sv =====
`timescale 1ns / 1ps

// TCP handshake client framer. A start transfer emits a 20-word SYN header
// and a matching SYN+ACK segment while waiting emits a 20-word ACK header,
// one word per cycle while the receiver is ready; other segments are
// consumed and produce nothing. The output word register is the pacing
// point. The front end checks the phase and computes both checksums in a
// 3-stage pipe, whose result then passes through the queue and the output
// word register, and parks up to four headers in the queue, so req_ready
// drops only when four are pending in pipe and queue together.
// Registers sit at byte address 4*index and must be written while idle.

module tcp_handshake_client_framer_top (
   input  logic                           clock,
   input  logic                           reset,
   tcphs_req_if.sink                      req_chan,
   tcphs_rsp_if.source                    rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tcphs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import tcphs_pkg::*;

   cfg_type           cfg;
   entry_type         push_data, head;
   logic              push, pop;
   logic [QCNT_W-1:0] q_count;

   tcphs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcphs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   tcphs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .count     (q_count)
   );

   tcphs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head     (head),
      .q_count  (q_count),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/tb_tcp_handshake_client_framer_top.sv =====
`timescale 1ns / 1ps

module tb_tcp_handshake_client_framer_top;
   import tcphs_pkg::*;

   localparam logic [15:0] SYN_BIT       = 16'h0002;
   localparam logic [15:0] ACK_BIT       = 16'h0010;
   localparam int          HDR_WORDS     = 20;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          MAX_SHOWN     = 10;

   typedef struct {
      logic        command;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        syn;
      logic        ack;
      logic [31:0] seq;
   } segment_type;

   typedef struct {
      logic [15:0] word;
      logic        last;
      logic        kind;
   } hdr_word_type;

   class handshake_scoreboard;
      cfg_type      cfg;
      phase_type    phase;
      logic [31:0]  peer_seq;
      hdr_word_type words_due[$];
      int           mismatches;
      int           words_seen;
      int           syn_hdrs;
      int           ack_hdrs;
      int           ignored;
      int           transfers_in;

      function new();
         cfg.source_address = 32'd2130706433;
         cfg.dest_address   = 32'd2130706433;
         cfg.local_port     = 16'd34463;
         cfg.remote_port    = 16'd12345;
         cfg.syn_sequence   = 32'd200;
         cfg.ack_sequence   = 32'd600;
         cfg.window_size    = 16'd8192;
         cfg.ip_ident       = 16'd34463;
         phase      = PH_IDLE;
         peer_seq   = '0;
         mismatches = 0;
         words_seen = 0;
         syn_hdrs   = 0;
         ack_hdrs   = 0;
         ignored    = 0;
         transfers_in = 0;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= MAX_SHOWN) $display("%s", msg);
      endfunction

      function int pending();
         return words_due.size();
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] val);
         case (idx)
            REG_SOURCE_ADDRESS: cfg.source_address = val;
            REG_DEST_ADDRESS:   cfg.dest_address   = val;
            REG_LOCAL_PORT:     cfg.local_port     = val[15:0];
            REG_REMOTE_PORT:    cfg.remote_port    = val[15:0];
            REG_SYN_SEQUENCE:   cfg.syn_sequence   = val;
            REG_ACK_SEQUENCE:   cfg.ack_sequence   = val;
            REG_WINDOW_SIZE:    cfg.window_size    = val[15:0];
            REG_IP_IDENT:       cfg.ip_ident       = val[15:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] csum_fold(logic [31:0] s);
         s = (s >> 16) + (s & 32'h0000_ffff);
         s = s + (s >> 16);
         return ~s[15:0];
      endfunction

      function void build_header(logic [31:0] seq, logic [31:0] ackno,
                                 logic [15:0] flags, logic kind);
         logic [15:0]  w[HDR_WORDS];
         logic [31:0]  s;
         hdr_word_type e;
         w[0]  = 16'h4500;
         w[1]  = 16'd40;
         w[2]  = cfg.ip_ident;
         w[3]  = 16'h0000;
         w[4]  = {8'd64, 8'd6};
         w[5]  = 16'h0000;
         w[6]  = cfg.source_address[31:16];
         w[7]  = cfg.source_address[15:0];
         w[8]  = cfg.dest_address[31:16];
         w[9]  = cfg.dest_address[15:0];
         w[10] = cfg.local_port;
         w[11] = cfg.remote_port;
         w[12] = seq[31:16];
         w[13] = seq[15:0];
         w[14] = ackno[31:16];
         w[15] = ackno[15:0];
         w[16] = 16'h5000 | flags;
         w[17] = cfg.window_size;
         w[18] = 16'h0000;
         w[19] = 16'h0000;
         s = '0;
         for (int i = 0; i < 10; i++) s += 32'(w[i]);
         w[5] = csum_fold(s);
         // pseudo header: addresses, protocol 6, TCP length 20
         s = 32'(w[6]) + 32'(w[7]) + 32'(w[8]) + 32'(w[9]) + 32'd26;
         for (int i = 10; i < HDR_WORDS; i++) s += 32'(w[i]);
         w[18] = csum_fold(s);
         for (int i = 0; i < HDR_WORDS; i++) begin
            e.word = w[i];
            e.last = (i == HDR_WORDS - 1);
            e.kind = kind;
            words_due.push_back(e);
         end
      endfunction

      function void note_request(segment_type t);
         transfers_in++;
         if (t.command == CMD_START) begin
            phase = PH_WAITING;
            build_header(cfg.syn_sequence, 32'd0, SYN_BIT, KIND_SYN);
            syn_hdrs++;
         end else if (phase == PH_WAITING && t.src_port == cfg.remote_port &&
                      t.dst_port == cfg.local_port && t.syn && t.ack) begin
            peer_seq = t.seq;
            phase    = PH_DONE;
            build_header(cfg.ack_sequence, peer_seq + 32'd1, ACK_BIT, KIND_ACK);
            ack_hdrs++;
         end else begin
            ignored++;
         end
      endfunction

      function void check_word(logic [15:0] word, logic last, logic kind);
         hdr_word_type e;
         words_seen++;
         if (words_due.size() == 0) begin
            report($sformatf("%0t: unexpected word %h last %b kind %b",
                             $realtime, word, last, kind));
            return;
         end
         e = words_due.pop_front();
         if (e.word !== word || e.last !== last || e.kind !== kind)
            report($sformatf("%0t: word exp %h/%b/%b got %h/%b/%b", $realtime,
                             e.word, e.last, e.kind, word, last, kind));
      endfunction

      function void final_check();
         if (words_due.size() != 0)
            report($sformatf("%0d header words never arrived", words_due.size()));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tcphs_req_if req_chan ();
   tcphs_rsp_if rsp_chan ();

   handshake_scoreboard sb;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_left;

   tcp_handshake_client_framer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver: long hold-off first, else random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_word(rsp_chan.packet_word, rsp_chan.last_word, rsp_chan.packet_kind);
   end

   function automatic segment_type mk(logic cmd, logic [15:0] sp, logic [15:0] dp,
                                      logic s, logic a, logic [31:0] q);
      segment_type t;
      t.command  = cmd;
      t.src_port = sp;
      t.dst_port = dp;
      t.syn      = s;
      t.ack      = a;
      t.seq      = q;
      return t;
   endfunction

   function automatic segment_type rand_start();
      return mk(CMD_START, 16'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom), $urandom);
   endfunction

   function automatic segment_type rand_reply(bit good);
      segment_type t;
      t = mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1, $urandom);
      if ($urandom_range(9) == 0) t.seq = '1;
      if (!good) begin
         case ($urandom_range(4))
            0: t.src_port = 16'($urandom);
            1: t.dst_port = 16'($urandom);
            2: t.syn = 1'b0;
            3: t.ack = 1'b0;
            default: t = mk(CMD_SEGMENT, 16'($urandom), 16'($urandom), 1'($urandom),
                            1'($urandom), $urandom);
         endcase
      end
      return t;
   endfunction

   task automatic send(segment_type t);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid          = 1'b1;
      req_chan.command        = t.command;
      req_chan.rx_source_port = t.src_port;
      req_chan.rx_dest_port   = t.dst_port;
      req_chan.rx_syn         = t.syn;
      req_chan.rx_ack         = t.ack;
      req_chan.rx_sequence    = t.seq;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(t);
   endtask

   // stop offering and let every expected word come out
   task automatic drain();
      int guard;
      @(negedge clock);
      req_chan.valid = 1'b0;
      guard = 0;
      while (sb.pending() > 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_all(logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) csr_write(reg_index_type'(i), vals[i]);
   endtask

   // start, some noise, then usually the SYN+ACK that completes it
   task automatic run_handshakes(int n_items);
      int sent;
      int noise;
      sent = 0;
      while (sent < n_items) begin
         send(rand_start());
         sent++;
         noise = $urandom_range(2);
         for (int k = 0; k < noise; k++) begin
            send(rand_reply(1'b0));
            sent++;
         end
         if ($urandom_range(9) < 8) begin
            send(rand_reply(1'b1));
            sent++;
         end
         if ($urandom_range(9) == 0) begin
            send(rand_reply(1'($urandom)));
            sent++;
         end
      end
   endtask

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [31:0] vals[8];
      sb = new();
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_chan.valid          = 1'b0;
      req_chan.command        = CMD_START;
      req_chan.rx_source_port = '0;
      req_chan.rx_dest_port   = '0;
      req_chan.rx_syn         = 1'b0;
      req_chan.rx_ack         = 1'b0;
      req_chan.rx_sequence    = '0;
      rsp_chan.ready = 1'b0;
      tx_idle_pct = 11;
      rx_idle_pct = 58;
      hold_left   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset register values
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1, 32'h1234));
      send(mk(CMD_START, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
      send(mk(CMD_SEGMENT, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'h0));
      send(mk(CMD_SEGMENT, 16'hffff, 16'hffff, 1'b1, 1'b1, 32'hffff_ffff));
      send(mk(CMD_SEGMENT, sb.cfg.local_port, sb.cfg.remote_port, 1'b1, 1'b1, 32'd5));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b0, 1'b1, 32'd9));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b0, 32'd9));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b0, 1'b0, 32'd9));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1,
              32'hffff_ffff));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1, 32'd7));
      send(mk(CMD_START, 16'hffff, 16'hffff, 1'b1, 1'b1, 32'hffff_ffff));
      send(mk(CMD_START, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1, 32'h0));
      send(mk(CMD_START, 16'h1234, 16'h4321, 1'b0, 1'b1, 32'h5555_aaaa));
      send(mk(CMD_SEGMENT, sb.cfg.remote_port, sb.cfg.local_port, 1'b1, 1'b1,
              32'h7fff_ffff));
      drain();

      // all-zero registers
      for (int i = 0; i < 8; i++) vals[i] = 32'h0;
      write_all(vals);
      run_handshakes(50);
      drain();

      // all-one registers, sender slow and receiver fast
      for (int i = 0; i < 8; i++) vals[i] = 32'hffff_ffff;
      write_all(vals);
      tx_idle_pct = 58;
      rx_idle_pct = 11;
      run_handshakes(50);
      drain();

      // random registers, no idling; receiver held off to back up the block
      for (int i = 0; i < 8; i++) vals[i] = $urandom;
      write_all(vals);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      @(posedge clock);
      hold_left = 400;
      for (int i = 0; i < 12; i++) send(rand_start());
      drain();
      run_handshakes(50);
      drain();

      // random registers, equal ports and addresses
      for (int i = 0; i < 8; i++) vals[i] = $urandom;
      vals[REG_REMOTE_PORT] = vals[REG_LOCAL_PORT];
      vals[REG_DEST_ADDRESS] = vals[REG_SOURCE_ADDRESS];
      write_all(vals);
      run_handshakes(50);
      drain();

      sb.final_check();
      $display("tb: %0d transfers in, %0d words out, %0d SYN and %0d ACK headers, %0d ignored",
               sb.transfers_in, sb.words_seen, sb.syn_hdrs, sb.ack_hdrs, sb.ignored);
      $display("tb: 5 register settings incl. all-zero and all-one, %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
